[design/current_sense_conditioner_top_assert.svh]
// assertion macros for the current sense conditioner
`ifndef CURRENT_SENSE_CONDITIONER_TOP_ASSERT_SVH
`define CURRENT_SENSE_CONDITIONER_TOP_ASSERT_SVH

// same-cycle implication
`define CSC_ASSERT_IMPL(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error("current sense conditioner assertion failed");

// next-cycle implication
`define CSC_ASSERT_NEXT(lbl, pre, post) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error("current sense conditioner assertion failed");

`endif

[design/csc_pkg.sv]
// shared types and constants of the current sense conditioner
package csc_pkg;

  localparam int unsigned CHANNELS = 4;
  localparam int unsigned CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  localparam logic signed [25:0] STEP_LIMIT = 26'sd983040;
  localparam logic signed [15:0] K_PRED     = 16'sd19661;
  localparam logic signed [15:0] K_FIRST    = 16'sd9830;
  localparam logic signed [15:0] K_SECOND   = 16'sd6554;
  localparam logic signed [41:0] RND_HALF   = 42'sd32768;

  localparam logic [2:0] REG_AMPS  = 3'd0;
  localparam logic [2:0] REG_OFF0  = 3'd1;
  localparam logic [2:0] REG_OFF1  = 3'd2;
  localparam logic [2:0] REG_OFF2  = 3'd3;
  localparam logic [2:0] REG_OFF3  = 3'd4;
  localparam logic [2:0] REG_LIMIT = 3'd5;
  localparam logic [2:0] REG_TRIP  = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_MUL,
    S_CLAMP,
    S_STEP,
    S_PRED,
    S_USED,
    S_E1M,
    S_E1,
    S_E2M,
    S_E2,
    S_SLM,
    S_SL,
    S_SRM,
    S_SR,
    S_WB
  } state_e;

  typedef struct packed {
    state_e stage;
    logic   start;
    logic   wb;
  } ctrl_t;

  typedef struct packed {
    logic signed [24:0] prev;
    logic signed [24:0] slope;
    logic signed [24:0] first;
    logic signed [24:0] second;
    logic [7:0]         trip;
  } entry_t;

  typedef struct packed {
    logic signed [24:0] speed_right;
    logic signed [24:0] speed_left;
    logic               overcurrent_fault;
    logic [7:0]         over_count;
    logic signed [24:0] filtered_current;
    logic signed [24:0] smoothed_current;
    logic signed [24:0] used_current;
    logic [1:0]         channel;
  } res_t;

endpackage

[design/current_sense_conditioner_top.sv]
// current sense conditioner top level: config registers, output register, assertions
// one word at a time: a word is accepted only while idle, and write-back, which waits
//   for a free output, must end first; set by the read-modify-write of the per-channel
//   state memory and the shared multiplier that steps through the filter chain
// reset clears control, loads register defaults and clears all channel state at once
//   through the state memory valid bits; no clearing pass is needed
`include "current_sense_conditioner_top_assert.svh"

module current_sense_conditioner_top (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [15:0]   s_axis_tdata,  // sample_count
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // channel, used_current, smoothed_current, filtered_current, over_count,
  // overcurrent_fault, speed_left, speed_right
  output logic [135:0]  m_axis_tdata,
  input  logic          cfg_we_i,
  input  logic [2:0]    cfg_addr_i,
  input  logic [63:0]   cfg_wdata_i
);

  logic [23:0]        apc_q;
  logic signed [24:0] off_q [4];
  logic [23:0]        lim_q;
  logic [63:0]        trip_q;

  csc_pkg::ctrl_t           ctrl;
  logic [csc_pkg::CH_W-1:0] ch_ptr;
  logic [1:0]               q;
  csc_pkg::entry_t          rd_ent, wr_ent;
  csc_pkg::res_t            res, out_res_q;
  logic                     out_valid_q, out_free, fault;
  logic signed [24:0]       lim_s;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      apc_q  <= '0;
      off_q  <= '{default: '0};
      lim_q  <= 24'hFFFFFF;
      trip_q <= '1;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        csc_pkg::REG_AMPS:  apc_q <= cfg_wdata_i[23:0];
        csc_pkg::REG_OFF0:  off_q[0] <= cfg_wdata_i[24:0];
        csc_pkg::REG_OFF1:  off_q[1] <= cfg_wdata_i[24:0];
        csc_pkg::REG_OFF2:  off_q[2] <= cfg_wdata_i[24:0];
        csc_pkg::REG_OFF3:  off_q[3] <= cfg_wdata_i[24:0];
        csc_pkg::REG_LIMIT: lim_q <= cfg_wdata_i[23:0];
        csc_pkg::REG_TRIP:  trip_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign q        = 2'(ch_ptr);
  assign out_free = !out_valid_q || m_axis_tready;

  csc_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .out_free_i (out_free),
    .fault_i    (fault),
    .in_ready_o (s_axis_tready),
    .ctrl_o     (ctrl),
    .ch_o       (ch_ptr)
  );

  csc_state_mem u_mem (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .rd_en_i   (ctrl.start),
    .rd_addr_i (ch_ptr),
    .wr_en_i   (ctrl.wb),
    .wr_addr_i (ch_ptr),
    .wr_data_i (wr_ent),
    .rd_data_o (rd_ent)
  );

  csc_datapath u_dp (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .ctrl_i           (ctrl),
    .ch_i             (ch_ptr),
    .sample_count_i   (s_axis_tdata),
    .amps_per_count_i (apc_q),
    .offset_i         (off_q[q]),
    .limit_i          (lim_q),
    .trip_level_i     (trip_q[{q, 4'b0} +: 16]),
    .ent_i            (rd_ent),
    .ent_o            (wr_ent),
    .res_o            (res),
    .fault_o          (fault)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (ctrl.wb) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl.wb) out_res_q <= res;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_res_q;
  assign lim_s         = $signed({1'b0, lim_q});

  `CSC_ASSERT_IMPL(a_fault_matches_count, m_axis_tvalid, out_res_q.overcurrent_fault == (out_res_q.over_count >= 8'd3))
  `CSC_ASSERT_NEXT(a_one_word_in_flight, s_axis_tvalid && s_axis_tready, !s_axis_tready)
  `CSC_ASSERT_IMPL(a_used_within_limit, m_axis_tvalid, out_res_q.used_current <= lim_s && out_res_q.used_current >= -lim_s)
  `CSC_ASSERT_NEXT(a_pointer_holds_on_fault, ctrl.wb && fault, ch_ptr == $past(ch_ptr))

endmodule

[design/csc_state_mem.sv]
// per-channel state memory with valid bits and registered read
module csc_state_mem (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     rd_en_i,
  input  logic [csc_pkg::CH_W-1:0] rd_addr_i,
  input  logic                     wr_en_i,
  input  logic [csc_pkg::CH_W-1:0] wr_addr_i,
  input  csc_pkg::entry_t          wr_data_i,
  output csc_pkg::entry_t          rd_data_o
);

  csc_pkg::entry_t                  mem [csc_pkg::CHANNELS];
  logic [csc_pkg::CHANNELS-1:0]     valid_q;
  csc_pkg::entry_t                  rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    if (rd_en_i) begin
      rd_data_q <= valid_q[rd_addr_i] ? mem[rd_addr_i] : '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else if (wr_en_i) begin
      valid_q[wr_addr_i] <= 1'b1;
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

[design/csc_ctrl.sv]
// sequencer and channel pointer
module csc_ctrl (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     out_free_i,
  input  logic                     fault_i,
  output logic                     in_ready_o,
  output csc_pkg::ctrl_t           ctrl_o,
  output logic [csc_pkg::CH_W-1:0] ch_o
);

  csc_pkg::state_e           state_q, state_d;
  logic [csc_pkg::CH_W-1:0]  ptr_q, ptr_d;
  logic                      start, wb;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= csc_pkg::S_IDLE;
      ptr_q   <= '0;
    end else begin
      state_q <= state_d;
      ptr_q   <= ptr_d;
    end
  end

  always_comb begin
    state_d = state_q;
    ptr_d   = ptr_q;
    start   = 1'b0;
    wb      = 1'b0;
    case (state_q)
      csc_pkg::S_IDLE: begin
        start = in_valid_i;
        if (in_valid_i) state_d = csc_pkg::S_MUL;
      end
      csc_pkg::S_MUL:   state_d = csc_pkg::S_CLAMP;
      csc_pkg::S_CLAMP: state_d = csc_pkg::S_STEP;
      csc_pkg::S_STEP:  state_d = csc_pkg::S_PRED;
      csc_pkg::S_PRED:  state_d = csc_pkg::S_USED;
      csc_pkg::S_USED:  state_d = csc_pkg::S_E1M;
      csc_pkg::S_E1M:   state_d = csc_pkg::S_E1;
      csc_pkg::S_E1:    state_d = csc_pkg::S_E2M;
      csc_pkg::S_E2M:   state_d = csc_pkg::S_E2;
      csc_pkg::S_E2:    state_d = csc_pkg::S_SLM;
      csc_pkg::S_SLM:   state_d = csc_pkg::S_SL;
      csc_pkg::S_SL:    state_d = csc_pkg::S_SRM;
      csc_pkg::S_SRM:   state_d = csc_pkg::S_SR;
      csc_pkg::S_SR:    state_d = csc_pkg::S_WB;
      csc_pkg::S_WB: begin
        if (out_free_i) begin
          wb      = 1'b1;
          state_d = csc_pkg::S_IDLE;
          if (!fault_i) begin
            ptr_d = (ptr_q == csc_pkg::CH_W'(csc_pkg::CHANNELS - 1)) ? '0 : ptr_q + 1'b1;
          end
        end
      end
      default: state_d = csc_pkg::S_IDLE;
    endcase
  end

  assign in_ready_o   = (state_q == csc_pkg::S_IDLE);
  assign ctrl_o.stage = state_q;
  assign ctrl_o.start = start;
  assign ctrl_o.wb    = wb;
  assign ch_o         = ptr_q;

endmodule

[design/csc_datapath.sv]
// arithmetic of one sample: scale, clamp, spike limit, slope filter, emas, trip count
module csc_datapath (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  csc_pkg::ctrl_t           ctrl_i,
  input  logic [csc_pkg::CH_W-1:0] ch_i,
  input  logic signed [15:0]       sample_count_i,
  input  logic [23:0]              amps_per_count_i,
  input  logic signed [24:0]       offset_i,
  input  logic [23:0]              limit_i,
  input  logic [15:0]              trip_level_i,
  input  csc_pkg::entry_t          ent_i,
  output csc_pkg::entry_t          ent_o,
  output csc_pkg::res_t            res_o,
  output logic                     fault_o
);

  logic signed [15:0] count_q;
  logic signed [40:0] prod_q;
  logic signed [41:0] mul_q;
  logic signed [24:0] a_q, slope_q, used_q, first_q, second_q;
  logic signed [24:0] sec0_q, sec1_q, sl_q, sr_q;
  logic [7:0]         cnt_q;
  logic               fault_q;

  logic signed [32:0] scaled;
  logic signed [33:0] ofs_sub, lim34;
  logic signed [24:0] a_clamp;
  logic signed [25:0] d, dlim, a_new;
  logic signed [26:0] sdiff;
  logic signed [24:0] slope_new;
  logic signed [25:0] rnd;
  logic signed [26:0] pred;
  logic signed [27:0] sum3;
  logic signed [25:0] used_raw, lim26;
  logic signed [24:0] used_new;
  logic signed [25:0] mul_a;
  logic signed [15:0] mul_k;
  logic signed [24:0] tgt0, tgt1;
  logic [24:0]        mag;
  logic               over;
  logic [7:0]         cnt_new;

  always_comb begin
    scaled  = 33'((prod_q + 41'sd128) >>> 8);
    ofs_sub = 34'(scaled) - 34'(offset_i);
    lim34   = $signed({10'b0, limit_i});
    if (ofs_sub > lim34) a_clamp = 25'(lim34);
    else if (ofs_sub < -lim34) a_clamp = 25'(-lim34);
    else a_clamp = 25'(ofs_sub);

    d = 26'(a_q) - 26'(ent_i.prev);
    if (d > csc_pkg::STEP_LIMIT) dlim = csc_pkg::STEP_LIMIT;
    else if (d < -csc_pkg::STEP_LIMIT) dlim = -csc_pkg::STEP_LIMIT;
    else dlim = d;
    a_new     = 26'(ent_i.prev) + dlim;
    sdiff     = 27'(dlim) - 27'(ent_i.slope);
    slope_new = 25'(27'(ent_i.slope) + (sdiff >>> 2));

    rnd      = 26'((mul_q + csc_pkg::RND_HALF) >>> 16);
    pred     = 27'(a_q) + 27'(rnd);
    sum3     = 28'(a_q) + 28'(a_q) + 28'(a_q) + 28'(pred);
    used_raw = 26'(sum3 >>> 2);
    lim26    = $signed({2'b0, limit_i});
    if (used_raw > lim26) used_new = 25'(lim26);
    else if (used_raw < -lim26) used_new = 25'(-lim26);
    else used_new = 25'(used_raw);

    tgt0 = (ch_i == csc_pkg::CH_W'(0)) ? second_q : sec0_q;
    tgt1 = (ch_i == csc_pkg::CH_W'(1)) ? second_q : sec1_q;

    mul_a = 26'(slope_q);
    mul_k = csc_pkg::K_PRED;
    case (ctrl_i.stage)
      csc_pkg::S_E1M: begin
        mul_a = 26'(used_q) - 26'(ent_i.first);
        mul_k = csc_pkg::K_FIRST;
      end
      csc_pkg::S_E2M: begin
        mul_a = 26'(first_q) - 26'(ent_i.second);
        mul_k = csc_pkg::K_SECOND;
      end
      csc_pkg::S_SLM: begin
        mul_a = 26'(tgt0) - 26'(sl_q);
        mul_k = csc_pkg::K_SECOND;
      end
      csc_pkg::S_SRM: begin
        mul_a = 26'(tgt1) - 26'(sr_q);
        mul_k = csc_pkg::K_SECOND;
      end
      default: begin
        mul_a = 26'(slope_q);
        mul_k = csc_pkg::K_PRED;
      end
    endcase

    mag  = used_q[24] ? 25'(-used_q) : 25'(used_q);
    over = mag > {1'b0, trip_level_i, 8'b0};
    if (!over) cnt_new = '0;
    else if (ent_i.trip == 8'hFF) cnt_new = ent_i.trip;
    else cnt_new = ent_i.trip + 8'd1;
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.start) count_q <= sample_count_i;
    case (ctrl_i.stage)
      csc_pkg::S_MUL:   prod_q <= count_q * $signed({1'b0, amps_per_count_i});
      csc_pkg::S_CLAMP: a_q <= a_clamp;
      csc_pkg::S_STEP: begin
        a_q     <= 25'(a_new);
        slope_q <= slope_new;
      end
      csc_pkg::S_USED: used_q <= used_new;
      csc_pkg::S_E1:   first_q <= 25'(26'(ent_i.first) + rnd);
      csc_pkg::S_E2: begin
        second_q <= 25'(26'(ent_i.second) + rnd);
        cnt_q    <= cnt_new;
        fault_q  <= over && (cnt_new >= 8'd3);
      end
      default: ;
    endcase
    if (ctrl_i.stage == csc_pkg::S_PRED || ctrl_i.stage == csc_pkg::S_E1M ||
        ctrl_i.stage == csc_pkg::S_E2M || ctrl_i.stage == csc_pkg::S_SLM ||
        ctrl_i.stage == csc_pkg::S_SRM) begin
      mul_q <= mul_a * mul_k;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sl_q   <= '0;
      sr_q   <= '0;
      sec0_q <= '0;
      sec1_q <= '0;
    end else begin
      if (ctrl_i.stage == csc_pkg::S_SL) sl_q <= 25'(26'(sl_q) + rnd);
      if (ctrl_i.stage == csc_pkg::S_SR) sr_q <= 25'(26'(sr_q) + rnd);
      if (ctrl_i.wb && ch_i == csc_pkg::CH_W'(0)) sec0_q <= second_q;
      if (ctrl_i.wb && ch_i == csc_pkg::CH_W'(1)) sec1_q <= second_q;
    end
  end

  assign ent_o.prev   = a_q;
  assign ent_o.slope  = slope_q;
  assign ent_o.first  = first_q;
  assign ent_o.second = second_q;
  assign ent_o.trip   = cnt_q;

  assign res_o.channel           = 2'(ch_i);
  assign res_o.used_current      = used_q;
  assign res_o.smoothed_current  = first_q;
  assign res_o.filtered_current  = second_q;
  assign res_o.over_count        = cnt_q;
  assign res_o.overcurrent_fault = fault_q;
  assign res_o.speed_left        = sl_q;
  assign res_o.speed_right       = sr_q;
  assign fault_o                 = fault_q;

endmodule
